>>> sv/wwrb_pkg.sv
// ----------------------------------------------------------------------------
// wwrb_pkg
// Shared types and constants for the word-wrap row breaker.
// ----------------------------------------------------------------------------
package wwrb_pkg;

  localparam logic [7:0] CharNul     = 8'h00;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;

  localparam logic [7:0] RowColumnsReset = 8'd80;

  typedef enum logic [1:0] {
    ClsEnd,
    ClsNewline,
    ClsBlank,
    ClsWord
  } char_class_e;

  // head of the front-to-back queue
  typedef struct packed {
    logic        valid;
    char_class_e cls;
  } item_t;

endpackage

>>> sv/wwrb_front.sv
// ----------------------------------------------------------------------------
// wwrb_front
// Accepts text bytes, classifies them, tags each with its text offset and
// holds them in a two-entry queue for the break engine.
// ----------------------------------------------------------------------------
module wwrb_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             character_i,
  output wwrb_pkg::item_t        head_o,
  output logic [OFFSET_BITS-1:0] head_pos_o,
  input  logic                   pop_i
);

  wwrb_pkg::char_class_e  cls_q [2];
  logic [OFFSET_BITS-1:0] pos_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             cnt_q, cnt_d;
  logic [OFFSET_BITS-1:0] text_pos_q, text_pos_d;
  wwrb_pkg::char_class_e  in_cls;
  logic                   push;
  logic                   pop;

  always_comb begin
    priority if (character_i == wwrb_pkg::CharNul) begin
      in_cls = wwrb_pkg::ClsEnd;
    end else if (character_i == wwrb_pkg::CharNewline) begin
      in_cls = wwrb_pkg::ClsNewline;
    end else if (character_i == wwrb_pkg::CharSpace || character_i == wwrb_pkg::CharTab) begin
      in_cls = wwrb_pkg::ClsBlank;
    end else begin
      in_cls = wwrb_pkg::ClsWord;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cls   = cls_q[rd_ptr_q];
  assign head_pos_o   = pos_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    text_pos_d = text_pos_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
      // end of text restarts offsets for the next text
      if (in_cls == wwrb_pkg::ClsEnd) begin
        text_pos_d = '0;
      end else begin
        text_pos_d = OFFSET_BITS'(text_pos_q + 1'b1);
      end
    end
    if (pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
      text_pos_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      text_pos_q <= text_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cls_q[wr_ptr_q] <= in_cls;
      pos_q[wr_ptr_q] <= text_pos_q;
    end
  end

endmodule

>>> sv/wwrb_back.sv
// ----------------------------------------------------------------------------
// wwrb_back
// Break engine: keeps the row state, decides row breaks for each queued byte
// and drives the result register.
// ----------------------------------------------------------------------------
module wwrb_back #(
  parameter int MAX_COLUMNS = 255,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_data_i,
  input  wwrb_pkg::item_t        head_i,
  input  logic [OFFSET_BITS-1:0] head_pos_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [15:0]            row_start_o,
  output logic [7:0]             row_length_o,
  output logic                   is_done_o,
  output logic [15:0]            row_count_o
);

  localparam logic [7:0] MaxCols = 8'(MAX_COLUMNS);

  logic [7:0]             row_columns_q;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [7:0]             scan_q, scan_d;
  logic                   lbi_vld_q, lbi_vld_d;
  logic [7:0]             lbi_q, lbi_d;
  logic                   skip_q, skip_d;
  logic [15:0]            rows_q, rows_d;
  logic                   flush_q, flush_d;

  logic                   out_valid_q;
  logic [15:0]            row_start_q;
  logic [7:0]             row_length_q;
  logic                   is_done_q;
  logic [15:0]            row_count_q;

  logic [7:0]             cols;
  logic [OFFSET_BITS-1:0] next_pos;
  logic                   emit;
  logic                   emit_done;
  logic                   hold;
  logic [OFFSET_BITS-1:0] emit_start;
  logic [7:0]             emit_len;
  logic [OFFSET_BITS+15:0] start_ext;
  logic                   out_free;
  logic                   take;

  always_comb begin
    priority if (row_columns_q == 8'd0) begin
      cols = 8'd1;
    end else if (row_columns_q > MaxCols) begin
      cols = MaxCols;
    end else begin
      cols = row_columns_q;
    end
  end

  assign next_pos = OFFSET_BITS'(head_pos_i + 1'b1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    start_d    = start_q;
    scan_d     = scan_q;
    lbi_vld_d  = lbi_vld_q;
    lbi_d      = lbi_q;
    skip_d     = skip_q;
    rows_d     = rows_q;
    flush_d    = flush_q;
    emit       = 1'b0;
    emit_done  = 1'b0;
    hold       = 1'b0;
    emit_start = start_q;
    emit_len   = scan_q;
    unique case (head_i.cls)
      wwrb_pkg::ClsEnd: begin
        if (!flush_q && !skip_q && scan_q != 8'd0) begin
          // flush the pending row first, the byte stays queued for the done beat
          emit    = 1'b1;
          hold    = 1'b1;
          flush_d = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_done = 1'b1;
          start_d   = '0;
          scan_d    = 8'd0;
          lbi_vld_d = 1'b0;
          skip_d    = 1'b0;
          rows_d    = 16'd0;
          flush_d   = 1'b0;
        end
      end
      default: begin
        priority if (skip_q) begin
          if (head_i.cls != wwrb_pkg::ClsBlank) begin
            skip_d    = 1'b0;
            lbi_vld_d = 1'b0;
            if (head_i.cls == wwrb_pkg::ClsNewline) begin
              start_d = next_pos;
              scan_d  = 8'd0;
            end else begin
              start_d = head_pos_i;
              scan_d  = 8'd1;
            end
          end
        end else if (head_i.cls == wwrb_pkg::ClsNewline) begin
          emit      = 1'b1;
          start_d   = next_pos;
          scan_d    = 8'd0;
          lbi_vld_d = 1'b0;
        end else if (scan_q < cols) begin
          if (scan_q == 8'd0) begin
            start_d = head_pos_i;
          end
          if (head_i.cls == wwrb_pkg::ClsBlank) begin
            lbi_vld_d = 1'b1;
            lbi_d     = scan_q;
          end
          scan_d = scan_q + 8'd1;
        end else if (head_i.cls == wwrb_pkg::ClsBlank) begin
          emit      = 1'b1;
          scan_d    = 8'd0;
          lbi_vld_d = 1'b0;
          skip_d    = 1'b1;
        end else if (lbi_vld_q && lbi_q != 8'd0 && lbi_q < scan_q) begin
          // back off to the last blank, the tail of the word moves down
          emit      = 1'b1;
          emit_len  = lbi_q;
          start_d   = OFFSET_BITS'(start_q + OFFSET_BITS'(lbi_q) + 1'b1);
          scan_d    = scan_q - lbi_q;
          lbi_vld_d = 1'b0;
        end else begin
          emit      = 1'b1;
          start_d   = head_pos_i;
          scan_d    = 8'd1;
          lbi_vld_d = 1'b0;
        end
        if (emit) begin
          rows_d = rows_q + 16'd1;
        end
      end
    endcase
    if (hold) begin
      rows_d = rows_q + 16'd1;
    end
  end

  assign take  = head_i.valid && (!emit || out_free);
  assign pop_o = take && !hold;

  assign start_ext = {16'd0, emit_start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_columns_q <= wwrb_pkg::RowColumnsReset;
      start_q       <= '0;
      scan_q        <= 8'd0;
      lbi_vld_q     <= 1'b0;
      skip_q        <= 1'b0;
      rows_q        <= 16'd0;
      flush_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        row_columns_q <= cfg_data_i;
      end
      if (take) begin
        start_q   <= start_d;
        scan_q    <= scan_d;
        lbi_vld_q <= lbi_vld_d;
        skip_q    <= skip_d;
        rows_q    <= rows_d;
        flush_q   <= flush_d;
      end
      if (take && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      lbi_q <= lbi_d;
    end
    if (take && emit) begin
      row_start_q  <= emit_done ? 16'd0 : start_ext[15:0];
      row_length_q <= emit_done ? 8'd0 : emit_len;
      is_done_q    <= emit_done;
      // done beat reports the total before the count restarts
      row_count_q  <= emit_done ? rows_q : rows_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_start_o  = row_start_q;
  assign row_length_o = row_length_q;
  assign is_done_o    = is_done_q;
  assign row_count_o  = row_count_q;

endmodule

>>> sv/word_wrap_row_breaker.sv
// ----------------------------------------------------------------------------
// word_wrap_row_breaker
// Greedy word wrap over a byte stream, reporting each row as offset and length.
// ----------------------------------------------------------------------------
// One text byte is taken per clock cycle while the input queue has room. An
// accepted byte is written into the input queue; the break engine works on
// the head of the queue and registers its result beat. The end-of-text byte
// stays at the head for a second pass of the break engine when a row is
// still pending, since the result register holds one beat at a time and
// that byte yields the final row and the done beat; every other byte is
// popped in a single pass. A two-entry queue between the classifier and
// the break engine lets input keep flowing while a result beat waits.
// The row_columns register is written through cfg_we_i / cfg_data_i and
// resets to 80; there is no clearing pass after reset.
module word_wrap_row_breaker #(
  parameter int MAX_COLUMNS = 255,
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] row_start_o,
  output logic [7:0]  row_length_o,
  output logic        is_done_o,
  output logic [15:0] row_count_o
);

  wwrb_pkg::item_t        head;
  logic [OFFSET_BITS-1:0] head_pos;
  logic                   pop;

  wwrb_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .head_o      (head),
    .head_pos_o  (head_pos),
    .pop_i       (pop)
  );

  wwrb_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .head_i       (head),
    .head_pos_i   (head_pos),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .row_start_o  (row_start_o),
    .row_length_o (row_length_o),
    .is_done_o    (is_done_o),
    .row_count_o  (row_count_o)
  );

endmodule

>>> sv/wwrb_checker.sv
// ----------------------------------------------------------------------------
// wwrb_checker
// Port-level checks for the word-wrap row breaker, bound to the top level.
// ----------------------------------------------------------------------------
module wwrb_checker #(
  parameter int MAX_COLUMNS = 255
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] row_start_o,
  input logic [7:0]  row_length_o,
  input logic        is_done_o,
  input logic [15:0] row_count_o
);

  // stalled beat stays up
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // stalled beat keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(row_start_o) && $stable(row_length_o)
      && $stable(is_done_o) && $stable(row_count_o))
    else $error("result payload changed while stalled");

  // done beat carries empty row fields
  a_done_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_done_o |-> row_start_o == 16'd0 && row_length_o == 8'd0)
    else $error("done beat with row fields set");

  // a row never exceeds the column ceiling
  a_row_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_done_o |-> row_length_o <= 8'(MAX_COLUMNS))
    else $error("row longer than the column ceiling");

endmodule

bind word_wrap_row_breaker wwrb_checker #(
  .MAX_COLUMNS (MAX_COLUMNS)
) u_wwrb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .row_start_o  (row_start_o),
  .row_length_o (row_length_o),
  .is_done_o    (is_done_o),
  .row_count_o  (row_count_o)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the word-wrap row breaker.
// ----------------------------------------------------------------------------
// Text bytes go in over a valid/ready channel while a predictor of the greedy
// wrap follows along. Each row beat that leaves the block is checked field by
// field against the oldest predicted beat. Directed texts cover blank lines,
// back-off to a space or tab, long words, blanks skipped after a break, the
// column limits and a limit lowered mid-row. Random texts then run under
// several column settings and idle mixes, and a run of newlines sends empty
// rows back to back.
module tb;

  localparam logic [8:0] NoBlank   = 9'h1FF;
  localparam int         StallMax  = 3000;
  localparam int         DrainWait = 8;

  typedef struct packed {
    logic [15:0] start;
    logic [7:0]  length;
    logic        done;
    logic [15:0] count;
  } row_beat_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_data_i  = 8'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  character_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] row_start_o;
  logic [7:0]  row_length_o;
  logic        is_done_o;
  logic [15:0] row_count_o;

  word_wrap_row_breaker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_start_o (row_start_o),
    .row_length_o(row_length_o),
    .is_done_o   (is_done_o),
    .row_count_o (row_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // wrap state mirrored from the block
  logic [7:0]  wrap_columns = wwrb_pkg::RowColumnsReset;
  logic [15:0] row_origin;
  logic [7:0]  row_fill;
  logic [8:0]  last_blank;
  logic        skipping;
  logic [15:0] text_pos;
  logic [15:0] rows_so_far;

  row_beat_t pending_rows[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatches    = 0;
  int        stall_cycles  = 0;

  function automatic void restart_text();
    row_origin  = 16'd0;
    row_fill    = 8'd0;
    last_blank  = NoBlank;
    skipping    = 1'b0;
    text_pos    = 16'd0;
    rows_so_far = 16'd0;
  endfunction

  function automatic void add_row(logic [15:0] start, logic [7:0] length, logic done);
    row_beat_t beat;
    if (!done) begin
      rows_so_far = rows_so_far + 16'd1;
    end
    beat.start  = start;
    beat.length = length;
    beat.done   = done;
    beat.count  = rows_so_far;
    pending_rows.push_back(beat);
  endfunction

  function automatic wwrb_pkg::char_class_e class_of(logic [7:0] ch);
    if (ch == wwrb_pkg::CharNul) return wwrb_pkg::ClsEnd;
    if (ch == wwrb_pkg::CharNewline) return wwrb_pkg::ClsNewline;
    if (ch == wwrb_pkg::CharSpace || ch == wwrb_pkg::CharTab) return wwrb_pkg::ClsBlank;
    return wwrb_pkg::ClsWord;
  endfunction

  // rows that one accepted byte breaks off
  function automatic void break_rows(logic [7:0] ch);
    logic [7:0]            cols;
    logic [15:0]           here;
    wwrb_pkg::char_class_e cls;
    cols = (wrap_columns == 8'd0) ? 8'd1 : wrap_columns;
    here = text_pos;
    cls  = class_of(ch);
    if (cls == wwrb_pkg::ClsEnd) begin
      if (!skipping && row_fill > 0) add_row(row_origin, row_fill, 1'b0);
      add_row(16'd0, 8'd0, 1'b1);
      restart_text();
      return;
    end
    text_pos = here + 16'd1;
    if (skipping) begin
      if (cls == wwrb_pkg::ClsBlank) return;
      skipping   = 1'b0;
      last_blank = NoBlank;
      if (cls == wwrb_pkg::ClsNewline) begin
        row_origin = text_pos;
        row_fill   = 8'd0;
      end else begin
        row_origin = here;
        row_fill   = 8'd1;
      end
      return;
    end
    if (cls == wwrb_pkg::ClsNewline) begin
      add_row(row_origin, row_fill, 1'b0);
      row_origin = text_pos;
      row_fill   = 8'd0;
      last_blank = NoBlank;
      return;
    end
    if (row_fill < cols) begin
      if (row_fill == 0) row_origin = here;
      if (cls == wwrb_pkg::ClsBlank) last_blank = {1'b0, row_fill};
      row_fill = row_fill + 8'd1;
      return;
    end
    // row is full
    if (cls == wwrb_pkg::ClsBlank) begin
      add_row(row_origin, row_fill, 1'b0);
      row_fill   = 8'd0;
      last_blank = NoBlank;
      skipping   = 1'b1;
      return;
    end
    if (last_blank != NoBlank && last_blank > 0 && last_blank < {1'b0, row_fill}) begin
      add_row(row_origin, last_blank[7:0], 1'b0);
      row_origin = row_origin + 16'(last_blank) + 16'd1;
      row_fill   = row_fill - last_blank[7:0];
    end else begin
      add_row(row_origin, row_fill, 1'b0);
      row_origin = here;
      row_fill   = 8'd1;
    end
    last_blank = NoBlank;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    row_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        $display("%0t: expected no beat, got start %0d length %0d done %0b count %0d",
                 $time, row_start_o, row_length_o, is_done_o, row_count_o);
      end else begin
        want = pending_rows.pop_front();
        if (row_start_o !== want.start || row_length_o !== want.length ||
            is_done_o !== want.done || row_count_o !== want.count) begin
          mismatches++;
          if (row_start_o !== want.start)
            $display("%0t: row_start expected %0d got %0d", $time, want.start, row_start_o);
          if (row_length_o !== want.length)
            $display("%0t: row_length expected %0d got %0d", $time, want.length,
                     row_length_o);
          if (is_done_o !== want.done)
            $display("%0t: is_done expected %0b got %0b", $time, want.done, is_done_o);
          if (row_count_o !== want.count)
            $display("%0t: row_count expected %0d got %0d", $time, want.count, row_count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallMax) begin
      $display("tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    break_rows(ch);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_columns(input logic [7:0] value);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    wrap_columns = value;
  endtask

  task automatic test_empty_text();
    send_char(wwrb_pkg::CharNul);
  endtask

  task automatic test_blank_lines();
    send_text("a\n\n");
    send_char(wwrb_pkg::CharNul);
  endtask

  // back-off to a tab, then blanks and one newline skipped after a break
  task automatic test_backoff();
    write_columns(8'd4);
    send_text("ab\tcd   \nz");
    send_char(wwrb_pkg::CharNul);
  endtask

  // blank at row position 0 gives no back-off, word cut at the limit
  task automatic test_long_word();
    write_columns(8'd3);
    send_text(" abcd");
    send_char(wwrb_pkg::CharNul);
  endtask

  task automatic test_column_limits();
    write_columns(8'd0);
    send_char(8'h01);
    send_char(8'hFF);
    send_char(wwrb_pkg::CharNul);
  endtask

  task automatic test_limit_lowered();
    write_columns(8'd8);
    send_text("abcd");
    write_columns(8'd2);
    send_char("g");
    send_char(wwrb_pkg::CharNul);
  endtask

  task automatic test_random_text(input int n_items);
    int sent;
    int pick;
    int n;
    int word_max;
    int text_len;
    logic [7:0] cols;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) write_columns(8'd255);
      else if (pick < 16) write_columns(8'd1);
      else if (pick < 20) write_columns(8'd0);
      else write_columns(8'($urandom_range(2, 16)));
      cols     = (wrap_columns == 8'd0) ? 8'd1 : wrap_columns;
      word_max = (cols > 12) ? 14 : cols + 3;
      text_len = $urandom_range(10, 50);
      n = 0;
      while (n < text_len) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          repeat ($urandom_range(1, word_max)) begin
            if ($urandom_range(9) == 0) send_char(8'($urandom_range(1, 255)));
            else send_char(8'("a" + $urandom_range(25)));
            n++;
          end
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 3)) begin
            send_char($urandom_range(1) ? wwrb_pkg::CharSpace : wwrb_pkg::CharTab);
            n++;
          end
        end else if (pick < 92) begin
          repeat ($urandom_range(1, 2)) begin
            send_char(wwrb_pkg::CharNewline);
            n++;
          end
        end else begin
          send_char(8'($urandom_range(1, 255)));
          n++;
        end
        if ($urandom_range(99) < 3) wait_drained();
      end
      // some texts stay open so the next setting lands mid-row
      if ($urandom_range(99) < 80) begin
        send_char(wwrb_pkg::CharNul);
        n++;
      end
      sent += n;
    end
    send_char(wwrb_pkg::CharNul);
  endtask

  // empty rows back to back, then a short text after them
  task automatic test_newline_run();
    write_columns(8'd3);
    repeat (30) send_char(wwrb_pkg::CharNewline);
    send_text("wrap it");
    send_char(wwrb_pkg::CharNul);
  endtask

  initial begin
    restart_text();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 59;
    test_empty_text();
    test_blank_lines();
    test_backoff();
    test_long_word();
    test_column_limits();
    test_limit_lowered();
    test_random_text(110);

    send_idle_pct = 59;
    recv_idle_pct = 28;
    test_random_text(110);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(110);
    test_newline_run();

    wait_drained();
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
